// ----- rtl/masked_markov_degree_walker_defines.svh -----
// Assertion macros for the masked Markov degree walker checker.
// Included by the checker file only; no dependencies.
`ifndef MASKED_MARKOV_DEGREE_WALKER_DEFINES_SVH
`define MASKED_MARKOV_DEGREE_WALKER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MMDW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define MMDW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mmdw_pkg.sv -----
// Package for the masked Markov degree walker: widths, constants, seed table,
// controller state, command and status types. No dependencies.
`timescale 1ns / 1ps

package mmdw_pkg;

   localparam int NUM_DEGREES_DEF = 7;
   localparam int DEG_W           = 3;
   localparam int MASK_W          = 7;
   localparam int WEIGHT_W        = 4;
   localparam int RNG_W           = 32;
   localparam int SUM_W           = 7;
   localparam int WALK_CAP        = 7;
   localparam int SEED_DIM        = 7;
   localparam int DEG_RESET       = 4;
   localparam int DIV_CNT_W       = $clog2(RNG_W + 1);
   localparam int XS_A            = 13;
   localparam int XS_B            = 17;
   localparam int XS_C            = 5;
   localparam int MUT_COL_SHIFT   = 4;
   localparam int MUT_VAL_LSB     = 8;

   localparam logic [RNG_W-1:0]    RNG_RESET   = 32'hDEADBEEF;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = 4'hF;

   localparam logic REQ_STEP   = 1'b0;
   localparam logic REQ_MUTATE = 1'b1;

   localparam logic [WEIGHT_W-1:0] SEED_TABLE [SEED_DIM][SEED_DIM] = '{
      '{4'd0, 4'd4, 4'd3, 4'd2, 4'd4, 4'd1, 4'd2},
      '{4'd5, 4'd0, 4'd3, 4'd2, 4'd1, 4'd1, 4'd0},
      '{4'd3, 4'd4, 4'd0, 4'd4, 4'd2, 4'd1, 4'd0},
      '{4'd2, 4'd2, 4'd3, 4'd0, 4'd4, 4'd2, 4'd1},
      '{4'd5, 4'd1, 4'd2, 4'd3, 4'd0, 4'd3, 4'd2},
      '{4'd1, 4'd2, 4'd1, 4'd2, 4'd3, 4'd0, 4'd3},
      '{4'd5, 4'd1, 4'd0, 4'd1, 4'd2, 4'd2, 4'd0}
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_DRAW,
      ST_DIV,
      ST_WALK,
      ST_MUT_DRAW,
      ST_MUT_QUOT,
      ST_MUT_REM,
      ST_MUT_WR,
      ST_FINISH
   } mmdw_state_type;

   typedef struct packed {
      logic capture;
      logic scan_clr;
      logic scan;
      logic walk;
      logic set_held;
      logic draw;
      logic div_start;
      logic div_step;
      logic commit;
      logic mut_fold;
      logic mut_quot;
      logic mut_rem;
      logic mut_write;
      logic load_rsp;
   } mmdw_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic sum_zero;
      logic div_done;
   } mmdw_status_type;

   function automatic logic [WEIGHT_W-1:0] seed_weight(input logic [3:0] row,
                                                       input logic [3:0] col);
      logic [WEIGHT_W-1:0] w;
      w = '0;
      if (row < 4'(SEED_DIM) && col < 4'(SEED_DIM)) begin
         w = SEED_TABLE[row[2:0]][col[2:0]];
      end
      return w;
   endfunction

endpackage

// ----- rtl/mmdw_if.sv -----
// Valid/ready channel interfaces for the request and response items.
// Depends on mmdw_pkg.
`timescale 1ns / 1ps

interface mmdw_req_if import mmdw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [MASK_W-1:0] allowed_mask;

   modport source (output valid, output req_type, output allowed_mask, input ready);
   modport sink   (input valid, input req_type, input allowed_mask, output ready);
endinterface

interface mmdw_rsp_if import mmdw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DEG_W-1:0] degree;
   logic             held;

   modport source (output valid, output degree, output held, input ready);
   modport sink   (input valid, input degree, input held, output ready);
endinterface

// ----- rtl/masked_markov_degree_walker.sv -----
// Masked Markov degree walker. Each request item yields exactly one response item.
// A step item sums the current row's weights over the masked degrees, draws a
// xorshift32 word, takes it modulo the sum and walks the row to pick the next
// degree; a zero sum keeps the degree and sets held. A mutate item draws one
// word and rewrites one weight. One item is in work at a time. The
// remainder unit is bit-serial, one dividend bit per cycle, and the row
// scans read the weight memory one column per cycle. A mutate item reduces
// its word modulo NUM_DEGREES by a byte fold, a reciprocal multiply and a
// remainder step, each registered. The weight table resets to its seed
// matrix at once through per-entry valid bits; no clearing pass is needed.
// Depends on mmdw_pkg, mmdw_if, mmdw_ctrl and mmdw_dp.
`timescale 1ns / 1ps

module masked_markov_degree_walker import mmdw_pkg::*; #(
   parameter int NUM_DEGREES = NUM_DEGREES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mmdw_req_if.sink  req_ch,
   mmdw_rsp_if.source rsp_ch
);

   mmdw_cmd_type    cmd;
   mmdw_status_type status;

   mmdw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mmdw_dp #(
      .NUM_DEGREES (NUM_DEGREES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .allowed_mask (req_ch.allowed_mask),
      .cmd          (cmd),
      .status       (status),
      .rsp_degree   (rsp_ch.degree),
      .rsp_held     (rsp_ch.held)
   );

endmodule

// ----- rtl/mmdw_ctrl.sv -----
// Controller state machine of the degree walker: sequences scan, draw,
// remainder and write phases and owns the handshakes. Depends on mmdw_pkg.
`timescale 1ns / 1ps

module mmdw_ctrl import mmdw_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_type,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  mmdw_status_type status,
   output mmdw_cmd_type    cmd
);

   mmdw_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture  = 1'b1;
               cmd.scan_clr = 1'b1;
               state_in     = (req_type == REQ_MUTATE) ? ST_MUT_DRAW : ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               if (status.sum_zero) begin
                  cmd.set_held = 1'b1;
                  state_in     = ST_FINISH;
               end else begin
                  state_in = ST_DRAW;
               end
            end
         end
         ST_DRAW: begin
            cmd.draw      = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               cmd.scan_clr = 1'b1;
               cmd.walk     = 1'b1;
               state_in     = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.scan = 1'b1;
            cmd.walk = 1'b1;
            if (status.scan_done) begin
               cmd.commit = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_MUT_DRAW: begin
            cmd.draw     = 1'b1;
            cmd.mut_fold = 1'b1;
            state_in     = ST_MUT_QUOT;
         end
         ST_MUT_QUOT: begin
            cmd.mut_quot = 1'b1;
            state_in     = ST_MUT_REM;
         end
         ST_MUT_REM: begin
            cmd.mut_rem = 1'b1;
            state_in    = ST_MUT_WR;
         end
         ST_MUT_WR: begin
            cmd.mut_write = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/mmdw_dp.sv -----
// Datapath of the degree walker: weight memory with seed fallback, xorshift
// generator, bit-serial remainder unit, constant-modulus reduction, row scan
// and output register. Depends on mmdw_pkg.
`timescale 1ns / 1ps

module mmdw_dp import mmdw_pkg::*; #(
   parameter int NUM_DEGREES = NUM_DEGREES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [MASK_W-1:0] allowed_mask,
   input  mmdw_cmd_type      cmd,
   output mmdw_status_type   status,
   output logic [DEG_W-1:0]  rsp_degree,
   output logic              rsp_held
);

   localparam int DEPTH    = NUM_DEGREES * NUM_DEGREES;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int ROW_W    = $clog2(NUM_DEGREES);
   localparam int WALK_N   = (NUM_DEGREES < WALK_CAP) ? NUM_DEGREES : WALK_CAP;
   localparam int CNT_W    = $clog2(WALK_N + 1);
   localparam int DEG_INIT = DEG_RESET % NUM_DEGREES;
   localparam int FOLD_W   = 14;
   localparam int RECIP_SH = 18;
   localparam int PROD_W   = FOLD_W + RECIP_SH;
   localparam int RECIP    = ((1 << RECIP_SH) + NUM_DEGREES - 1) / NUM_DEGREES;
   localparam int FOLD_C1  = (1 << 8) % NUM_DEGREES;
   localparam int FOLD_C2  = (1 << 16) % NUM_DEGREES;
   localparam int FOLD_C3  = (1 << 24) % NUM_DEGREES;

   logic [WEIGHT_W-1:0]  weight_mem_ff [DEPTH];
   logic [DEPTH-1:0]     weight_vld_ff;
   logic [WEIGHT_W-1:0]  rd_mem_ff;
   logic [WEIGHT_W-1:0]  rd_seed_ff;
   logic                 rd_vld_ff;
   logic                 rd_pend_ff;
   logic [DEG_W-1:0]     rd_col_ff;
   logic [CNT_W-1:0]     col_ff;

   logic [RNG_W-1:0]     rng_ff;
   logic [DEG_W-1:0]     degree_ff;
   logic [MASK_W-1:0]    mask_ff;
   logic                 held_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SUM_W-1:0]     pick_ff;
   logic                 found_ff;
   logic [DEG_W-1:0]     next_deg_ff;

   logic [SUM_W-1:0]     rem_ff;
   logic [SUM_W-1:0]     divisor_ff;
   logic [RNG_W-1:0]     div_sh_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   logic [FOLD_W-1:0]    row_fold_ff, col_fold_ff;
   logic [FOLD_W-1:0]    row_quot_ff, col_quot_ff;
   logic [ROW_W-1:0]     row_rem_ff, col_rem_ff;

   logic [DEG_W-1:0]     rsp_degree_ff;
   logic                 rsp_held_ff;

   logic [RNG_W-1:0]     xs_a, xs_b, rng_nx;
   logic [SUM_W:0]       div_trial, div_diff;
   logic                 div_done;
   logic                 issue;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   logic [WEIGHT_W-1:0]  rd_weight;
   logic                 lane_hit;
   logic [PROD_W-1:0]    row_prod, col_prod;
   logic [FOLD_W-1:0]    row_rem_full, col_rem_full;

   // fold a word into a small value with the same residue modulo NUM_DEGREES
   function automatic logic [FOLD_W-1:0] fold_word(input logic [RNG_W-1:0] v);
      return FOLD_W'(v[7:0])
           + FOLD_W'(v[15:8])  * FOLD_W'(FOLD_C1)
           + FOLD_W'(v[23:16]) * FOLD_W'(FOLD_C2)
           + FOLD_W'(v[31:24]) * FOLD_W'(FOLD_C3);
   endfunction

   assign xs_a   = rng_ff ^ (rng_ff << XS_A);
   assign xs_b   = xs_a ^ (xs_a >> XS_B);
   assign rng_nx = xs_b ^ (xs_b << XS_C);

   assign div_trial = {rem_ff, div_sh_ff[RNG_W-1]};
   assign div_diff  = div_trial - {1'b0, divisor_ff};
   assign div_done  = (div_cnt_ff == DIV_CNT_W'(RNG_W));

   assign row_prod     = PROD_W'(row_fold_ff) * PROD_W'(RECIP);
   assign col_prod     = PROD_W'(col_fold_ff) * PROD_W'(RECIP);
   assign row_rem_full = row_fold_ff - row_quot_ff * FOLD_W'(NUM_DEGREES);
   assign col_rem_full = col_fold_ff - col_quot_ff * FOLD_W'(NUM_DEGREES);

   assign issue   = cmd.scan && (col_ff != CNT_W'(WALK_N));
   assign rd_addr = ADDR_W'(ADDR_W'(degree_ff) * ADDR_W'(NUM_DEGREES)) + ADDR_W'(col_ff);
   assign wr_addr = ADDR_W'(ADDR_W'(row_rem_ff) * ADDR_W'(NUM_DEGREES))
                    + ADDR_W'(col_rem_ff);

   assign rd_weight = rd_vld_ff ? rd_mem_ff : rd_seed_ff;
   assign lane_hit  = rd_pend_ff && mask_ff[rd_col_ff];

   // weight memory, one read and one write port
   always_ff @(posedge clock) begin
      if (cmd.mut_write) begin
         weight_mem_ff[wr_addr] <= rng_ff[MUT_VAL_LSB +: WEIGHT_W] & WEIGHT_MASK;
      end
      rd_mem_ff  <= weight_mem_ff[rd_addr];
      rd_seed_ff <= seed_weight(4'(degree_ff), 4'(col_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_vld_ff <= '0;
         rd_vld_ff     <= 1'b0;
         rd_pend_ff    <= 1'b0;
         col_ff        <= '0;
         rng_ff        <= RNG_RESET;
         degree_ff     <= DEG_W'(DEG_INIT);
         div_cnt_ff    <= DIV_CNT_W'(RNG_W);
      end else begin
         rd_vld_ff <= weight_vld_ff[rd_addr];
         if (cmd.mut_write) begin
            weight_vld_ff[wr_addr] <= 1'b1;
         end
         if (cmd.scan_clr) begin
            col_ff     <= '0;
            rd_pend_ff <= 1'b0;
         end else begin
            rd_pend_ff <= issue;
            if (issue) begin
               col_ff <= col_ff + CNT_W'(1);
            end
         end
         if (cmd.draw) begin
            rng_ff <= rng_nx;
         end
         if (cmd.commit && found_ff) begin
            degree_ff <= next_deg_ff;
         end
         if (cmd.div_start) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step && !div_done) begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_col_ff <= DEG_W'(col_ff);
      if (cmd.capture) begin
         mask_ff <= allowed_mask;
         held_ff <= 1'b0;
      end else if (cmd.set_held) begin
         held_ff <= 1'b1;
      end
      // row scan: sum pass, then weighted walk
      if (cmd.scan_clr) begin
         sum_ff   <= '0;
         pick_ff  <= rem_ff;
         found_ff <= 1'b0;
      end else if (lane_hit) begin
         if (cmd.walk) begin
            if (!found_ff) begin
               if (pick_ff < SUM_W'(rd_weight)) begin
                  found_ff    <= 1'b1;
                  next_deg_ff <= rd_col_ff;
               end else begin
                  pick_ff <= pick_ff - SUM_W'(rd_weight);
               end
            end
         end else begin
            sum_ff <= sum_ff + SUM_W'(rd_weight);
         end
      end
      // restoring remainder, one dividend bit per cycle
      if (cmd.div_start) begin
         rem_ff     <= '0;
         div_sh_ff  <= rng_nx;
         divisor_ff <= sum_ff;
      end else if (cmd.div_step && !div_done) begin
         div_sh_ff <= div_sh_ff << 1;
         if (div_trial >= {1'b0, divisor_ff}) begin
            rem_ff <= div_diff[SUM_W-1:0];
         end else begin
            rem_ff <= div_trial[SUM_W-1:0];
         end
      end
      // mutate address: fold, reciprocal quotient, remainder
      if (cmd.mut_fold) begin
         row_fold_ff <= fold_word(rng_nx);
         col_fold_ff <= fold_word(rng_nx >> MUT_COL_SHIFT);
      end
      if (cmd.mut_quot) begin
         row_quot_ff <= row_prod[PROD_W-1:RECIP_SH];
         col_quot_ff <= col_prod[PROD_W-1:RECIP_SH];
      end
      if (cmd.mut_rem) begin
         row_rem_ff <= row_rem_full[ROW_W-1:0];
         col_rem_ff <= col_rem_full[ROW_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_degree_ff <= degree_ff;
         rsp_held_ff   <= held_ff;
      end
   end

   assign status.scan_done = (col_ff == CNT_W'(WALK_N)) && !rd_pend_ff;
   assign status.sum_zero  = (sum_ff == '0);
   assign status.div_done  = div_done;

   assign rsp_degree = rsp_degree_ff;
   assign rsp_held   = rsp_held_ff;

endmodule

// ----- rtl/mmdw_checker.sv -----
// Port-level checker for the degree walker and its bind to the top level.
// Depends on mmdw_pkg and masked_markov_degree_walker_defines.svh.
`timescale 1ns / 1ps
`include "masked_markov_degree_walker_defines.svh"

module mmdw_checker import mmdw_pkg::*; #(
   parameter int NUM_DEGREES = NUM_DEGREES_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [DEG_W-1:0] rsp_degree,
   input logic             rsp_held
);

   `MMDW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_degree) && $stable(rsp_held), "stalled response item changed")

   `MMDW_ASSERT_IMPL(a_deg_range, clock, reset, rsp_valid, (32'(rsp_degree) < NUM_DEGREES) && (rsp_degree != 3'd7), "response degree out of range")

   `MMDW_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second item accepted while one is in work")

   `MMDW_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "response item raised right after accept")

endmodule

bind masked_markov_degree_walker mmdw_checker #(
   .NUM_DEGREES (NUM_DEGREES)
) u_mmdw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_degree (rsp_ch.degree),
   .rsp_held   (rsp_ch.held)
);

// ----- sim/tb.sv -----
// Self-checking bench for masked_markov_degree_walker: a table of directed items, then
// random step and mutate items, each checked against a known result from the table
// or an in-bench walker model. Depends on mmdw_pkg, mmdw_if and the walker RTL.
`timescale 1ns / 1ps

module tb;
   import mmdw_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1650;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLDOFF_LEN  = 400;
   localparam int HOLDOFF_AT   = 150;
   localparam int DIR_COUNT    = 24;

   typedef struct packed {
      logic [DEG_W-1:0] degree;
      logic             held;
   } walk_move_type;

   typedef struct packed {
      logic              kind;
      logic [MASK_W-1:0] mask;
      logic              known;
      logic [DEG_W-1:0]  degree;
      logic              held;
   } dir_row_type;

   localparam dir_row_type DIRECTED_ROWS [DIR_COUNT] = '{
      '{REQ_STEP,   7'h00, 1'b1, 3'd4, 1'b1},
      '{REQ_STEP,   7'h10, 1'b1, 3'd4, 1'b1},
      '{REQ_STEP,   7'h01, 1'b1, 3'd0, 1'b0},
      '{REQ_STEP,   7'h01, 1'b1, 3'd0, 1'b1},
      '{REQ_STEP,   7'h40, 1'b1, 3'd6, 1'b0},
      '{REQ_STEP,   7'h04, 1'b1, 3'd6, 1'b1},
      '{REQ_MUTATE, 7'h00, 1'b1, 3'd6, 1'b0},
      '{REQ_MUTATE, 7'h7F, 1'b1, 3'd6, 1'b0},
      '{REQ_STEP,   7'h7F, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h7F, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h2A, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h55, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h01, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h02, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h08, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h20, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h00, 1'b0, 3'd0, 1'b0},
      '{REQ_MUTATE, 7'h55, 1'b0, 3'd0, 1'b0},
      '{REQ_MUTATE, 7'h2A, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h7F, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h3C, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h7E, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h0F, 1'b0, 3'd0, 1'b0},
      '{REQ_STEP,   7'h70, 1'b0, 3'd0, 1'b0}
   };

   logic clock;
   logic reset;

   mmdw_req_if req_ch ();
   mmdw_rsp_if rsp_ch ();

   masked_markov_degree_walker u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // walker model state
   logic [WEIGHT_W-1:0] walker_weights [NUM_DEGREES_DEF][NUM_DEGREES_DEF];
   logic [RNG_W-1:0]    walker_rng;
   logic [DEG_W-1:0]    walker_degree;

   walk_move_type pending_moves_q [$];
   int            error_count;
   int            moves_taken;
   int            cycle_count;
   logic          row_known;
   walk_move_type row_move;
   logic          bursting;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [RNG_W-1:0] draw_walker_word();
      logic [RNG_W-1:0] x;
      x = walker_rng;
      x = x ^ (x << XS_A);
      x = x ^ (x >> XS_B);
      x = x ^ (x << XS_C);
      walker_rng = x;
      return x;
   endfunction

   task automatic predict_walker(input logic kind, input logic [MASK_W-1:0] mask,
                                 output walk_move_type move);
      logic [RNG_W-1:0] word;
      logic [RNG_W-1:0] total;
      logic [RNG_W-1:0] pick;
      logic             found;
      int               row;
      row = int'(walker_degree);
      move.held = 1'b0;
      if (kind == REQ_STEP) begin
         total = '0;
         for (int col = 0; col < NUM_DEGREES_DEF; col++) begin
            if (mask[col]) begin
               total += RNG_W'(walker_weights[row][col]);
            end
         end
         if (total == '0) begin
            move.held = 1'b1;
         end else begin
            word = draw_walker_word();
            pick = word % total;
            found = 1'b0;
            for (int col = 0; col < NUM_DEGREES_DEF; col++) begin
               if (mask[col] && !found) begin
                  if (pick < RNG_W'(walker_weights[row][col])) begin
                     walker_degree = DEG_W'(col);
                     found = 1'b1;
                  end else begin
                     pick -= RNG_W'(walker_weights[row][col]);
                  end
               end
            end
         end
      end else begin
         word = draw_walker_word();
         walker_weights[word % NUM_DEGREES_DEF][(word >> MUT_COL_SHIFT) % NUM_DEGREES_DEF] =
            word[MUT_VAL_LSB +: WEIGHT_W];
      end
      move.degree = walker_degree;
   endtask

   function automatic int pick_gap(input logic calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(15, 40);
   endfunction

   // offer one item from a falling edge; return at the falling edge after its accept
   task automatic send_item(input logic kind, input logic [MASK_W-1:0] mask,
                            input logic known, input walk_move_type move);
      int gap;
      if ($urandom_range(0, 63) == 0) begin
         bursting = !bursting;
      end
      gap = pick_gap(bursting);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        = 1'b1;
      req_ch.req_type     = kind;
      req_ch.allowed_mask = mask;
      row_known           = known;
      row_move            = move;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      walk_move_type predicted;
      walk_move_type wanted;
      if (!reset && req_ch.valid && req_ch.ready) begin
         predict_walker(req_ch.req_type, req_ch.allowed_mask, predicted);
         pending_moves_q.push_back(row_known ? row_move : predicted);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         moves_taken++;
         if (pending_moves_q.size() == 0) begin
            $error("unexpected result item: degree %0d held %0d", rsp_ch.degree, rsp_ch.held);
            error_count++;
         end else begin
            wanted = pending_moves_q.pop_front();
            if (rsp_ch.degree !== wanted.degree) begin
               $error("degree mismatch: expected %0d, actual %0d", wanted.degree,
                      rsp_ch.degree);
               error_count++;
            end
            if (rsp_ch.held !== wanted.held) begin
               $error("held mismatch: expected %0d, actual %0d", wanted.held, rsp_ch.held);
               error_count++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // result side: random stalls, one long hold-off that backs up the input
   initial begin
      int run_len;
      int stall;
      logic held_off;
      held_off = 1'b0;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (!held_off && moves_taken >= HOLDOFF_AT) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLDOFF_LEN) @(negedge clock);
            held_off = 1'b1;
         end
         run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 4);
         rsp_ch.ready = 1'b1;
         repeat (run_len) @(negedge clock);
         stall = pick_gap(1'b0);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   initial begin
      logic              kind;
      logic [MASK_W-1:0] mask;
      int                pick;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_STEP;
      req_ch.allowed_mask = '0;
      row_known           = 1'b0;
      row_move            = '0;
      bursting            = 1'b0;
      error_count         = 0;
      moves_taken         = 0;
      for (int r = 0; r < NUM_DEGREES_DEF; r++) begin
         for (int c = 0; c < NUM_DEGREES_DEF; c++) begin
            walker_weights[r][c] = SEED_TABLE[r][c];
         end
      end
      walker_rng    = RNG_RESET;
      walker_degree = DEG_W'(DEG_RESET % NUM_DEGREES_DEF);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_COUNT; i++) begin
         send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].mask, DIRECTED_ROWS[i].known,
                   '{DIRECTED_ROWS[i].degree, DIRECTED_ROWS[i].held});
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = ($urandom_range(0, 9) < 3) ? REQ_MUTATE : REQ_STEP;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            mask = '0;
         end else if (pick < 18) begin
            mask = '1;
         end else if (pick < 33) begin
            mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
         end else begin
            mask = MASK_W'($urandom_range(0, 127));
         end
         send_item(kind, mask, 1'b0, '0);
      end
      req_ch.valid = 1'b0;

      while (pending_moves_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mmdw_pkg.sv
rtl/mmdw_if.sv
rtl/mmdw_ctrl.sv
rtl/mmdw_dp.sv
rtl/masked_markov_degree_walker.sv
rtl/mmdw_checker.sv
sim/tb.sv
